// ===== hw/rtl/escape_sequence_field_decoder_assert.svh =====
// ----------------------------------------------------------------------------
// Escape sequence field decoder assertion macros
// Shorthand for clocked checks that are disabled during reset.
// ----------------------------------------------------------------------------
`ifndef ESCAPE_SEQUENCE_FIELD_DECODER_ASSERT_SVH
`define ESCAPE_SEQUENCE_FIELD_DECODER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent
`define ESFD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define ESFD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/esfd_pkg.sv =====
// ----------------------------------------------------------------------------
// esfd_pkg
// Types and character codes shared by the escape sequence field decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package esfd_pkg;

  // Most words one raw byte can produce, and the result queue depth
  localparam int MAX_RESULTS = 3;
  localparam int FIFO_DEPTH  = 4;
  localparam int CNT_W       = 2;   // holds 0..MAX_RESULTS
  localparam int PTR_W       = 2;   // indexes FIFO_DEPTH entries
  localparam int FILL_W      = 3;   // holds 0..FIFO_DEPTH

  // Character codes
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_ESC   = 8'h1B;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_SEVEN = 8'h37;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_E  = 8'h45;
  localparam logic [7:0] CH_UP_F  = 8'h46;
  localparam logic [7:0] CH_UP_Z  = 8'h5A;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_CARET = 8'h5E;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_D  = 8'h64;
  localparam logic [7:0] CH_LO_F  = 8'h66;
  localparam logic [7:0] CH_LO_N  = 8'h6E;
  localparam logic [7:0] CH_LO_O  = 8'h6F;
  localparam logic [7:0] CH_LO_R  = 8'h72;
  localparam logic [7:0] CH_LO_X  = 8'h78;
  localparam logic [7:0] CH_PIPE  = 8'h7C;

  // Offsets that turn a letter into its control code or hex digit value
  localparam logic [7:0] CTRL_OFS   = 8'h40;  // 'A' - 1
  localparam logic [7:0] HEX_LO_OFS = 8'h57;  // 'a' - 10
  localparam logic [7:0] HEX_UP_OFS = 8'h37;  // 'A' - 10

  // One result word
  typedef struct packed {
    logic [7:0] out_byte;
    logic       field_end;
  } result_t;

  // All words produced by one raw byte
  typedef struct packed {
    logic [CNT_W-1:0]                 cnt;
    result_t [MAX_RESULTS-1:0]        res;
  } step_t;

  // Result queue status
  typedef struct packed {
    logic [FILL_W-1:0] fill;
    logic              has_room;
  } fifo_stat_t;

endpackage

// ===== hw/rtl/esfd_decode.sv =====
// ----------------------------------------------------------------------------
// esfd_decode
// Escape state registers and the single-pass decode of one raw byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module esfd_decode (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            step_en,
  input  logic [7:0]      in_byte,
  input  logic            in_eob,
  output esfd_pkg::step_t step
);
  import esfd_pkg::*;

  typedef enum logic [2:0] {
    MODE_IDLE  = 3'd0,
    MODE_CARET = 3'd1,
    MODE_BSL   = 3'd2,
    MODE_PCT   = 3'd3,
    MODE_DEC   = 3'd4,
    MODE_OCT   = 3'd5,
    MODE_HEX   = 3'd6
  } mode_t;

  mode_t       mode_r, mode_nxt;
  logic [7:0]  acc_r, acc_nxt;
  logic [1:0]  dig_r, dig_nxt;

  logic        p_end;
  logic        p_emit;
  mode_t       p_mode;
  logic        dig_ok;
  logic [3:0]  dig_val;
  logic [7:0]  acc_mul;
  logic [7:0]  acc_new;
  logic [1:0]  dig_new;
  logic [1:0]  dig_lim;

  // Classify the byte as if no escape were pending
  always_comb begin
    p_end  = (in_byte == CH_NUL) || (in_byte == CH_LF) || (in_byte == CH_PIPE);
    p_mode = MODE_IDLE;
    if (in_byte == CH_CARET) begin
      p_mode = MODE_CARET;
    end else if (in_byte == CH_BSL) begin
      p_mode = MODE_BSL;
    end else if (in_byte == CH_PCT) begin
      p_mode = MODE_PCT;
    end
    p_emit = !p_end && (p_mode == MODE_IDLE);
  end

  // Digit value in the current radix
  always_comb begin
    dig_ok  = 1'b0;
    dig_val = 4'd0;
    if (mode_r == MODE_DEC) begin
      if (in_byte inside {[CH_ZERO:CH_NINE]}) begin
        dig_ok  = 1'b1;
        dig_val = in_byte[3:0];
      end
    end else if (mode_r == MODE_OCT) begin
      if (in_byte inside {[CH_ZERO:CH_SEVEN]}) begin
        dig_ok  = 1'b1;
        dig_val = in_byte[3:0];
      end
    end else begin
      if (in_byte inside {[CH_ZERO:CH_NINE]}) begin
        dig_ok  = 1'b1;
        dig_val = in_byte[3:0];
      end else if (in_byte inside {[CH_LO_A:CH_LO_F]}) begin
        dig_ok  = 1'b1;
        dig_val = 4'(in_byte - HEX_LO_OFS);
      end else if (in_byte inside {[CH_UP_A:CH_UP_F]}) begin
        dig_ok  = 1'b1;
        dig_val = 4'(in_byte - HEX_UP_OFS);
      end
    end
  end

  // Accumulate one digit, modulo 256
  always_comb begin
    case (mode_r)
      MODE_DEC: acc_mul = {acc_r[4:0], 3'b000} + {acc_r[6:0], 1'b0};
      MODE_OCT: acc_mul = {acc_r[4:0], 3'b000};
      default:  acc_mul = {acc_r[3:0], 4'b0000};
    endcase
    acc_new = acc_mul + {4'd0, dig_val};
    dig_new = dig_r + 2'd1;
    dig_lim = (mode_r == MODE_HEX) ? 2'd2 : 2'd3;
  end

  // Decode one byte into up to three words and the next escape state
  always_comb begin
    logic       ended;
    logic       do_plain;
    logic [1:0] n;
    result_t    res [MAX_RESULTS];

    ended    = 1'b0;
    do_plain = 1'b0;
    n        = 2'd0;
    mode_nxt = mode_r;
    acc_nxt  = acc_r;
    dig_nxt  = dig_r;
    for (int i = 0; i < MAX_RESULTS; i++) begin
      res[i] = '0;
    end

    case (mode_r)
      MODE_CARET: begin
        mode_nxt = MODE_IDLE;
        if (in_byte inside {[CH_UP_A:CH_UP_Z]}) begin
          res[n] = '{out_byte: in_byte - CTRL_OFS, field_end: 1'b0};
          n      = n + 2'd1;
        end else begin
          res[n]   = '{out_byte: CH_CARET, field_end: 1'b0};
          n        = n + 2'd1;
          do_plain = (in_byte != CH_CARET);
        end
      end
      MODE_BSL: begin
        mode_nxt = MODE_IDLE;
        if ((in_byte == CH_NUL) || (in_byte == CH_LF)) begin
          res[n] = '{out_byte: 8'd0, field_end: 1'b1};
          ended  = 1'b1;
        end else if (in_byte == CH_UP_E) begin
          res[n] = '{out_byte: CH_ESC, field_end: 1'b0};
        end else if (in_byte == CH_LO_N) begin
          res[n] = '{out_byte: CH_LF, field_end: 1'b0};
        end else if (in_byte == CH_LO_R) begin
          res[n] = '{out_byte: CH_CR, field_end: 1'b0};
        end else begin
          res[n] = '{out_byte: in_byte, field_end: 1'b0};
        end
        n = n + 2'd1;
      end
      MODE_PCT: begin
        mode_nxt = MODE_IDLE;
        if (in_byte == CH_LO_D) begin
          mode_nxt = MODE_DEC;
        end else if ((in_byte == CH_LO_O) || (in_byte == CH_ZERO)) begin
          mode_nxt = MODE_OCT;
        end else if (in_byte == CH_LO_X) begin
          mode_nxt = MODE_HEX;
        end else if (in_byte == CH_PCT) begin
          res[n] = '{out_byte: CH_PCT, field_end: 1'b0};
          n      = n + 2'd1;
        end else begin
          do_plain = 1'b1;
        end
      end
      MODE_DEC, MODE_OCT, MODE_HEX: begin
        if (dig_ok) begin
          acc_nxt = acc_new;
          dig_nxt = dig_new;
          if (dig_new >= dig_lim) begin
            res[n]   = '{out_byte: acc_new, field_end: 1'b0};
            n        = n + 2'd1;
            mode_nxt = MODE_IDLE;
            acc_nxt  = 8'd0;
            dig_nxt  = 2'd0;
          end
        end else begin
          res[n]   = '{out_byte: acc_r, field_end: 1'b0};
          n        = n + 2'd1;
          do_plain = 1'b1;
        end
      end
      default: begin
        do_plain = 1'b1;
      end
    endcase

    // Handle the byte with no escape pending
    if (do_plain) begin
      mode_nxt = p_mode;
      acc_nxt  = 8'd0;
      dig_nxt  = 2'd0;
      if (p_end) begin
        res[n] = '{out_byte: 8'd0, field_end: 1'b1};
        n      = n + 2'd1;
        ended  = 1'b1;
      end else if (p_emit) begin
        res[n] = '{out_byte: in_byte, field_end: 1'b0};
        n      = n + 2'd1;
      end
    end

    // End of buffer: flush a pending caret or number, then close the field
    if (in_eob && !ended) begin
      if (mode_nxt == MODE_CARET) begin
        res[n] = '{out_byte: CH_CARET, field_end: 1'b0};
        n      = n + 2'd1;
      end else if ((mode_nxt == MODE_DEC) || (mode_nxt == MODE_OCT) ||
                   (mode_nxt == MODE_HEX)) begin
        res[n] = '{out_byte: acc_nxt, field_end: 1'b0};
        n      = n + 2'd1;
      end
      res[n]   = '{out_byte: 8'd0, field_end: 1'b1};
      n        = n + 2'd1;
      mode_nxt = MODE_IDLE;
      acc_nxt  = 8'd0;
      dig_nxt  = 2'd0;
    end

    // A field end always leaves the decoder idle
    if (ended) begin
      mode_nxt = MODE_IDLE;
      acc_nxt  = 8'd0;
      dig_nxt  = 2'd0;
    end

    step.cnt = n;
    for (int i = 0; i < MAX_RESULTS; i++) begin
      step.res[i] = res[i];
    end
  end

  // Advance the escape state on each decoded byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE;
      acc_r  <= 8'd0;
      dig_r  <= 2'd0;
    end else if (step_en) begin
      mode_r <= mode_nxt;
      acc_r  <= acc_nxt;
      dig_r  <= dig_nxt;
    end
  end

endmodule

// ===== hw/rtl/esfd_result_fifo.sv =====
// ----------------------------------------------------------------------------
// esfd_result_fifo
// Small result queue: takes up to three words at once, sends one per cycle on pop.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module esfd_result_fifo (
  input  logic                 clk,
  input  logic                 rst_n,
  input  esfd_pkg::step_t      push,
  input  logic                 pop,
  output esfd_pkg::result_t    head,
  output logic                 head_valid,
  output esfd_pkg::fifo_stat_t stat
);
  import esfd_pkg::*;

  result_t           mem_r [FIFO_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;

  // Pointer and fill count updates
  always_comb begin
    wr_ptr_nxt = wr_ptr_r + PTR_W'(push.cnt);
    rd_ptr_nxt = rd_ptr_r + PTR_W'(pop);
    fill_nxt   = fill_r + FILL_W'(push.cnt) - FILL_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  // Write the new words at consecutive slots
  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_RESULTS; i++) begin
      if (CNT_W'(i) < push.cnt) begin
        mem_r[wr_ptr_r + PTR_W'(i)] <= push.res[i];
      end
    end
  end

  assign head          = mem_r[rd_ptr_r];
  assign head_valid    = (fill_r != '0);
  assign stat.fill     = fill_r;
  assign stat.has_room = (fill_r <= FILL_W'(FIFO_DEPTH - MAX_RESULTS));

endmodule

// ===== hw/rtl/escape_sequence_field_decoder.sv =====
// ----------------------------------------------------------------------------
// escape_sequence_field_decoder
// Termcap-style escape decoder: raw bytes in, decoded bytes and field ends out.
// ----------------------------------------------------------------------------
// One raw byte enters per cycle while in_tready is high and is registered,
// decoded in a single pass against the escape state, and its zero to three
// result words go into a four-entry result queue that sends one word per
// cycle while out_tready is high. With out_tready high, a byte that yields
// at most one word sustains one byte per clock; a byte that yields two or
// three words (a digit run cut short, a flush at end of buffer) holds the
// input while the queue drains, so the output port's one word per cycle
// sets the rate. out_tlast high marks a field end with tdata zero.
`timescale 1ns / 1ps

module escape_sequence_field_decoder (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,    // [7:0] in_byte
  input  logic       in_tlast,    // end_of_buffer
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,   // [7:0] out_byte
  output logic       out_tlast    // field_end
);
  import esfd_pkg::*;

  logic        in_valid_r;
  logic [7:0]  in_byte_r;
  logic        in_eob_r;
  logic        consume;
  logic        pop;
  step_t       step;
  step_t       push;
  result_t     head;
  fifo_stat_t  stat;

  // Decode the held byte once the queue can take its words
  assign consume   = in_valid_r && stat.has_room;
  assign in_tready = !in_valid_r || consume;
  assign pop       = out_tvalid && out_tready;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r <= in_tdata;
      in_eob_r  <= in_tlast;
    end
  end

  esfd_decode u_decode (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (consume),
    .in_byte (in_byte_r),
    .in_eob  (in_eob_r),
    .step    (step)
  );

  // Push only the words of a decoded byte
  always_comb begin
    push     = step;
    push.cnt = consume ? step.cnt : '0;
  end

  esfd_result_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .pop        (pop),
    .head       (head),
    .head_valid (out_tvalid),
    .stat       (stat)
  );

  assign out_tdata = head.out_byte;
  assign out_tlast = head.field_end;

  `include "escape_sequence_field_decoder_assert.svh"

  `ESFD_ASSERT_NOW(a_fill_bound, 1'b1, stat.fill <= FILL_W'(FIFO_DEPTH), "queue overfilled")
  `ESFD_ASSERT_NOW(a_end_zero, out_tvalid && out_tlast, out_tdata == 8'd0, "field end with data")
  `ESFD_ASSERT_NEXT(a_hold_byte, in_valid_r && !consume, in_valid_r, "held byte lost")
  `ESFD_ASSERT_NOW(a_push_room, consume, stat.fill + FILL_W'(step.cnt) <= FILL_W'(FIFO_DEPTH), "push overflows queue")

endmodule
